### design/rbcr_pkg.sv
package rbcr_pkg;

   localparam int IDX_W   = 13;
   localparam int AMT_W   = 16;
   localparam int TYPE_W  = 3;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W  = $clog2(QUEUE_DEPTH);

   localparam int BUF_DEPTH = 4096;
   localparam logic [IDX_W-1:0] SIZE_MAX   = IDX_W'(BUF_DEPTH);
   localparam logic [IDX_W-1:0] SIZE_RESET = IDX_W'(4096);

   localparam int RSP_DATA_W = 32;

   localparam logic [TYPE_W-1:0] REQ_RESERVE = 3'd0;
   localparam logic [TYPE_W-1:0] REQ_CONSUME = 3'd1;
   localparam logic [TYPE_W-1:0] REQ_PEEK    = 3'd2;
   localparam logic [TYPE_W-1:0] REQ_PENDING = 3'd3;
   localparam logic [TYPE_W-1:0] REQ_CLEAR   = 3'd4;

   typedef enum logic [2:0] {
      OP_RESERVE,
      OP_CONSUME,
      OP_PEEK,
      OP_PENDING,
      OP_CLEAR,
      OP_BAD
   } op_type;

   typedef struct packed {
      op_type             op;
      logic               zero_amt;
      logic [AMT_W-1:0]   amount;
   } cmd_type;

endpackage

### design/rbcr_front.sv
module rbcr_front (
   input  logic [rbcr_pkg::TYPE_W-1:0] req_type,
   input  logic [rbcr_pkg::AMT_W-1:0]  req_amount,
   input  logic                        req_valid,
   input  logic                        queue_full,
   output logic                        req_ready,
   output logic                        push,
   output rbcr_pkg::cmd_type           cmd
);
   import rbcr_pkg::*;

   always_comb begin
      case (req_type)
         REQ_RESERVE: cmd.op = OP_RESERVE;
         REQ_CONSUME: cmd.op = OP_CONSUME;
         REQ_PEEK:    cmd.op = OP_PEEK;
         REQ_PENDING: cmd.op = OP_PENDING;
         REQ_CLEAR:   cmd.op = OP_CLEAR;
         default:     cmd.op = OP_BAD;
      endcase
      cmd.zero_amt = (req_amount == '0);
      cmd.amount   = req_amount;
   end

   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full;

endmodule

### design/rbcr_queue.sv
module rbcr_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rbcr_pkg::cmd_type push_cmd,
   input  logic              pop,
   output logic              full,
   output logic              not_empty,
   output rbcr_pkg::cmd_type head_cmd
);
   import rbcr_pkg::*;

   cmd_type                entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]        count_ff, count_in;
   logic                   do_push, do_pop;

   assign full      = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_cmd  = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### design/rbcr_back.sv
module rbcr_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [rbcr_pkg::IDX_W-1:0]  csr_wr_data,
   input  logic                        cmd_valid,
   input  rbcr_pkg::cmd_type           cmd,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [rbcr_pkg::IDX_W-1:0]  rsp_granted,
   output logic [rbcr_pkg::IDX_W-1:0]  rsp_offset,
   output logic                        rsp_status
);
   import rbcr_pkg::*;

   logic [IDX_W-1:0] size_ff, size_in;
   logic [IDX_W-1:0] widx_ff, widx_in;
   logic [IDX_W-1:0] ridx_ff, ridx_in;
   logic             valid_ff, valid_in;
   logic [IDX_W-1:0] granted_ff, granted_in;
   logic [IDX_W-1:0] offset_ff, offset_in;
   logic             status_ff, status_in;

   logic [IDX_W-1:0] size_eff;
   logic             wrapped;
   logic [IDX_W-1:0] contig;
   logic [IDX_W-1:0] pending;
   logic             res_err;
   logic [IDX_W-1:0] res_base;
   logic [IDX_W-1:0] res_avail;
   logic [IDX_W-1:0] res_grant;
   logic [IDX_W-1:0] res_next_w;
   logic [IDX_W-1:0] con_grant;
   logic [IDX_W-1:0] con_next_r;
   logic [IDX_W-1:0] con_next_w;

   assign pop       = cmd_valid && (!valid_ff || rsp_ready);
   assign rsp_valid = valid_ff;
   assign rsp_granted = granted_ff;
   assign rsp_offset  = offset_ff;
   assign rsp_status  = status_ff;

   always_comb begin
      if (size_ff == '0) begin
         size_eff = IDX_W'(1);
      end else if (size_ff > SIZE_MAX) begin
         size_eff = SIZE_MAX;
      end else begin
         size_eff = size_ff;
      end

      wrapped = (ridx_ff > widx_ff) || ((ridx_ff == widx_ff) && (ridx_ff != '0));
      if (wrapped) begin
         contig  = (size_eff >= ridx_ff) ? size_eff - ridx_ff : '0;
         pending = contig + widx_ff;
      end else begin
         contig  = widx_ff - ridx_ff;
         pending = widx_ff - ridx_ff;
      end

      res_err   = 1'b0;
      res_base  = widx_ff;
      res_avail = '0;
      if (widx_ff < ridx_ff) begin
         res_avail = ridx_ff - widx_ff;
      end else if ((ridx_ff != '0) && (widx_ff == ridx_ff)) begin
         res_err = 1'b1;
      end else if (widx_ff < size_eff) begin
         res_avail = size_eff - widx_ff;
      end else if (ridx_ff == '0) begin
         res_err = 1'b1;
      end else begin
         res_base  = '0;
         res_avail = ridx_ff;
      end
      res_grant  = (cmd.amount < AMT_W'(res_avail)) ? cmd.amount[IDX_W-1:0] : res_avail;
      res_next_w = res_base + res_grant;
      if ((res_next_w == size_eff) && (ridx_ff != '0)) begin
         res_next_w = '0;
      end

      con_grant  = (cmd.amount < AMT_W'(contig)) ? cmd.amount[IDX_W-1:0] : contig;
      con_next_r = ridx_ff + con_grant;
      con_next_w = widx_ff;
      if (con_next_r == size_eff) begin
         con_next_r = '0;
         if (widx_ff == size_eff) begin
            con_next_w = '0;
         end
      end
      if (con_next_r == con_next_w) begin
         con_next_r = '0;
         con_next_w = '0;
      end
   end

   always_comb begin
      size_in    = size_ff;
      widx_in    = widx_ff;
      ridx_in    = ridx_ff;
      valid_in   = valid_ff && !rsp_ready;
      granted_in = granted_ff;
      offset_in  = offset_ff;
      status_in  = status_ff;

      if (pop) begin
         valid_in   = 1'b1;
         granted_in = '0;
         offset_in  = '0;
         status_in  = 1'b0;
         case (cmd.op)
            OP_RESERVE: begin
               if (cmd.zero_amt) begin
                  offset_in = widx_ff;
               end else if (res_err) begin
                  status_in = 1'b1;
               end else begin
                  granted_in = res_grant;
                  offset_in  = res_base;
                  widx_in    = res_next_w;
               end
            end
            OP_CONSUME: begin
               if (cmd.zero_amt) begin
                  offset_in = ridx_ff;
               end else if (contig == '0) begin
                  status_in = 1'b1;
               end else begin
                  granted_in = con_grant;
                  offset_in  = ridx_ff;
                  ridx_in    = con_next_r;
                  widx_in    = con_next_w;
               end
            end
            OP_PEEK: begin
               granted_in = contig;
               offset_in  = ridx_ff;
            end
            OP_PENDING: begin
               granted_in = pending;
            end
            OP_CLEAR: begin
               widx_in = '0;
               ridx_in = '0;
            end
            default: begin
               status_in = 1'b1;
            end
         endcase
      end

      if (csr_wr_en) begin
         size_in = csr_wr_data;
         widx_in = '0;
         ridx_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff  <= SIZE_RESET;
         widx_ff  <= '0;
         ridx_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         size_ff  <= size_in;
         widx_ff  <= widx_in;
         ridx_ff  <= ridx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      granted_ff <= granted_in;
      offset_ff  <= offset_in;
      status_ff  <= status_in;
   end

endmodule

### design/ring_buffer_chunk_reserve.sv
// Index manager for a byte ring buffer that hands out contiguous chunks: each request word
// reserves write space, consumes or peeks at readable bytes, reports the pending count or
// clears both indices, and returns exactly one response word in request order. Requests are
// decoded on entry and held in a two-entry queue; the execute stage then updates the write
// and read indices and loads a response register. One request is retired per clock cycle
// unless responses stall; each goes via a queue entry and the response register. A stall
// on the response side fills the queue first, after which req_tready drops. Writing the
// size register clears both indices and must be done only while no request is outstanding.
module ring_buffer_chunk_reserve (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [rbcr_pkg::IDX_W-1:0]          csr_wr_data,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [rbcr_pkg::AMT_W-1:0]          req_tdata,  // amount
   input  logic [rbcr_pkg::TYPE_W-1:0]         req_tuser,  // req_type
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [rbcr_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // granted, offset, zero fill
   output logic                                rsp_tuser   // status
);
   import rbcr_pkg::*;

   cmd_type          front_cmd;
   cmd_type          head_cmd;
   logic             push;
   logic             pop;
   logic             queue_full;
   logic             queue_not_empty;
   logic [IDX_W-1:0] granted;
   logic [IDX_W-1:0] offset;

   rbcr_front u_front (
      .req_type   (req_tuser),
      .req_amount (req_tdata),
      .req_valid  (req_tvalid),
      .queue_full (queue_full),
      .req_ready  (req_tready),
      .push       (push),
      .cmd        (front_cmd)
   );

   rbcr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (front_cmd),
      .pop       (pop),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .head_cmd  (head_cmd)
   );

   rbcr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd_valid   (queue_not_empty),
      .cmd         (head_cmd),
      .pop         (pop),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_granted (granted),
      .rsp_offset  (offset),
      .rsp_status  (rsp_tuser)
   );

   assign rsp_tdata = {{(RSP_DATA_W - 2*IDX_W){1'b0}}, offset, granted};

endmodule

### design/rbcr_checker.sv
module rbcr_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            csr_wr_en,
   input logic [rbcr_pkg::IDX_W-1:0]      csr_wr_data,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [rbcr_pkg::AMT_W-1:0]      req_tdata,
   input logic [rbcr_pkg::TYPE_W-1:0]     req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [rbcr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tuser
);
   import rbcr_pkg::*;

   // An error response carries neither a grant nor an offset.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata[2*IDX_W-1:0] == '0))
      else $error("error response with nonzero grant or offset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata[IDX_W-1:0] <= SIZE_MAX)
                      && (rsp_tdata[2*IDX_W-1:IDX_W] <= SIZE_MAX)))
      else $error("grant or offset beyond buffer depth");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[RSP_DATA_W-1:2*IDX_W] == '0))
      else $error("response fill bits not zero");

   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response word present after reset");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled response word changed");

endmodule

bind ring_buffer_chunk_reserve rbcr_checker u_rbcr_checker (.*);

### sim/tb.sv
`timescale 1ns / 100ps

module tb;
   import rbcr_pkg::*;

   localparam logic [TYPE_W-1:0] REQ_BAD_FIRST = 3'd5;
   localparam logic [TYPE_W-1:0] REQ_BAD_LAST  = 3'd7;
   localparam int HOLD_PHASE   = 5;
   localparam int LONG_HOLD    = 80;
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int PRINT_LIMIT  = 100;

   typedef struct {
      logic [TYPE_W-1:0] kind;
      logic [AMT_W-1:0]  amount;
   } req_word_type;

   typedef struct {
      logic [IDX_W-1:0] granted;
      logic [IDX_W-1:0] offset;
      logic             status;
   } grant_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [IDX_W-1:0] csr_wr_data = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [AMT_W-1:0] req_tdata = '0;
   logic [TYPE_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic rsp_tuser;

   ring_buffer_chunk_reserve uut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   always #5 clock = ~clock;

   req_word_type req_backlog[$];
   grant_type expected_grants[$];
   logic [IDX_W-1:0] size_reg = SIZE_RESET;
   int wr_idx = 0;
   int rd_idx = 0;
   int sent_count = 0;
   int total_queued = 0;
   int phase_no = 0;
   int err_count = 0;
   int cycle_count = 0;
   bit idle_on = 1'b1;

   function automatic int active_size(logic [IDX_W-1:0] raw);
      int s;
      s = raw;
      if (s < 1) s = 1;
      if (s > BUF_DEPTH) s = BUF_DEPTH;
      return s;
   endfunction

   function automatic int readable_run(int size);
      if (rd_idx > wr_idx || (rd_idx == wr_idx && rd_idx > 0)) begin
         return (size >= rd_idx) ? size - rd_idx : 0;
      end
      return wr_idx - rd_idx;
   endfunction

   function automatic grant_type ring_predict(logic [TYPE_W-1:0] kind, logic [AMT_W-1:0] amt);
      int size;
      int num;
      int sz;
      bit no_room;
      bit wrapped;
      grant_type g;
      size = active_size(size_reg);
      num = amt;
      sz = 0;
      no_room = 1'b0;
      wrapped = rd_idx > wr_idx || (rd_idx == wr_idx && rd_idx > 0);
      g.granted = '0;
      g.offset = '0;
      g.status = 1'b0;
      case (kind)
         REQ_RESERVE: begin
            if (num == 0) begin
               g.offset = IDX_W'(wr_idx);
            end else begin
               if (wr_idx < rd_idx) sz = rd_idx - wr_idx;
               else if (rd_idx > 0 && wr_idx == rd_idx) no_room = 1'b1;
               else if (wr_idx < size) sz = size - wr_idx;
               else if (rd_idx == 0) no_room = 1'b1;
               else begin
                  wr_idx = 0;
                  sz = rd_idx;
               end
               if (no_room) begin
                  g.status = 1'b1;
               end else begin
                  if (num < sz) sz = num;
                  g.offset = IDX_W'(wr_idx);
                  g.granted = IDX_W'(sz);
                  wr_idx += sz;
                  if (wr_idx == size && rd_idx > 0) wr_idx = 0;
               end
            end
         end
         REQ_CONSUME: begin
            if (num == 0) begin
               g.offset = IDX_W'(rd_idx);
            end else begin
               sz = readable_run(size);
               if (sz == 0) begin
                  g.status = 1'b1;
               end else begin
                  if (num < sz) sz = num;
                  g.offset = IDX_W'(rd_idx);
                  g.granted = IDX_W'(sz);
                  rd_idx += sz;
                  if (rd_idx == size) begin
                     rd_idx = 0;
                     if (wr_idx == size) wr_idx = 0;
                  end
                  if (rd_idx == wr_idx) begin
                     rd_idx = 0;
                     wr_idx = 0;
                  end
               end
            end
         end
         REQ_PEEK: begin
            g.offset = IDX_W'(rd_idx);
            g.granted = IDX_W'(readable_run(size));
         end
         REQ_PENDING: begin
            if (wrapped) begin
               sz = ((size >= rd_idx) ? size - rd_idx : 0) + wr_idx;
            end else begin
               sz = wr_idx - rd_idx;
            end
            g.granted = IDX_W'(sz);
         end
         REQ_CLEAR: begin
            rd_idx = 0;
            wr_idx = 0;
         end
         default: begin
            g.status = 1'b1;
         end
      endcase
      wr_idx &= 32'h1FFF;
      rd_idx &= 32'h1FFF;
      return g;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      err_count++;
      if (err_count <= PRINT_LIMIT) begin
         $display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
      end
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin : drive
      int gap_left;
      req_word_type w;
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_grants.push_back(ring_predict(req_tuser, req_tdata));
            sent_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (idle_on && req_backlog.size() > 0 && $urandom_range(0, 7) == 0) begin
               gap_left = $urandom_range(1, 17) - 1;
               req_tvalid <= 1'b0;
            end else if (req_backlog.size() > 0) begin
               w = req_backlog.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= w.amount;
               req_tuser <= w.kind;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : watch
      int stall_left;
      int hold_left;
      bit held;
      grant_type g;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
         hold_left = 0;
         held = 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_grants.size() == 0) begin
               report_mismatch("unexpected response", rsp_tdata, 0);
            end else begin
               g = expected_grants.pop_front();
               if (rsp_tdata[12:0] !== g.granted)
                  report_mismatch("granted", rsp_tdata[12:0], g.granted);
               if (rsp_tdata[25:13] !== g.offset)
                  report_mismatch("offset", rsp_tdata[25:13], g.offset);
               if (rsp_tdata[31:26] !== 6'd0)
                  report_mismatch("zero fill", rsp_tdata[31:26], 0);
               if (rsp_tuser !== g.status)
                  report_mismatch("status", rsp_tuser, g.status);
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (phase_no == HOLD_PHASE && !held) begin
            held = 1'b1;
            hold_left = LONG_HOLD - 1;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 17) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic queue_word(input logic [TYPE_W-1:0] kind, input logic [AMT_W-1:0] amt);
      req_word_type w;
      w.kind = kind;
      w.amount = amt;
      req_backlog.push_back(w);
      total_queued++;
   endtask

   task automatic wait_drained();
      while (sent_count != total_queued || expected_grants.size() != 0) @(posedge clock);
   endtask

   task automatic write_size(input logic [IDX_W-1:0] value);
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      size_reg = value;
      wr_idx = 0;
      rd_idx = 0;
   endtask

   function automatic logic [AMT_W-1:0] pick_amount(int size);
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return AMT_W'($urandom_range(0, 65535));
      if (r == 2) return AMT_W'(size);
      return AMT_W'($urandom_range(1, size));
   endfunction

   task automatic run_phase(input logic [IDX_W-1:0] value, input int count, input bit idle);
      int size;
      int r;
      write_size(value);
      idle_on = idle;
      size = active_size(value);
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < 40) queue_word(REQ_RESERVE, pick_amount(size));
         else if (r < 75) queue_word(REQ_CONSUME, pick_amount(size));
         else if (r < 83) queue_word(REQ_PEEK, AMT_W'($urandom_range(0, 65535)));
         else if (r < 91) queue_word(REQ_PENDING, AMT_W'($urandom_range(0, 65535)));
         else if (r < 95) queue_word(REQ_CLEAR, AMT_W'($urandom_range(0, 65535)));
         else queue_word(TYPE_W'($urandom_range(REQ_BAD_FIRST, REQ_BAD_LAST)),
                         AMT_W'($urandom_range(0, 65535)));
      end
      phase_no++;
   endtask

   initial begin : stimulus
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Reset size: fill the whole buffer, find it full, then drain it in one chunk.
      queue_word(REQ_RESERVE, 16'hFFFF);
      queue_word(REQ_RESERVE, 16'd1);
      queue_word(REQ_PENDING, 16'd0);
      queue_word(REQ_CONSUME, 16'hFFFF);

      write_size(13'd8);
      queue_word(REQ_PENDING, 16'd0);
      queue_word(REQ_PEEK, 16'd0);
      queue_word(REQ_CONSUME, 16'd5);
      queue_word(REQ_RESERVE, 16'd0);
      queue_word(REQ_CONSUME, 16'd0);
      queue_word(REQ_RESERVE, 16'hFFFF);
      queue_word(REQ_RESERVE, 16'd1);
      queue_word(REQ_CONSUME, 16'd3);
      // Write index sits at the end, so this reserve wraps to the front.
      queue_word(REQ_RESERVE, 16'd5);
      queue_word(REQ_RESERVE, 16'd1);
      queue_word(REQ_PEEK, 16'd0);
      queue_word(REQ_PENDING, 16'd0);
      queue_word(REQ_CONSUME, 16'hFFFF);
      queue_word(REQ_CONSUME, 16'd2);
      queue_word(REQ_CONSUME, 16'd1);
      // The reserve that reaches the end drops the write index to zero behind the reader.
      queue_word(REQ_RESERVE, 16'd5);
      queue_word(REQ_CONSUME, 16'd2);
      queue_word(REQ_RESERVE, 16'd3);
      queue_word(REQ_PEEK, 16'd0);
      queue_word(REQ_PENDING, 16'd0);
      queue_word(REQ_RESERVE, 16'd0);
      queue_word(REQ_CLEAR, 16'hFFFF);
      queue_word(REQ_BAD_FIRST, 16'hFFFF);
      queue_word(REQ_BAD_LAST, 16'd0);

      run_phase(13'd1, 70, 1'b1);
      run_phase(13'd0, 70, 1'b1);
      run_phase(13'd4096, 70, 1'b1);
      run_phase(13'h1FFF, 70, 1'b1);
      run_phase(13'd3, 70, 1'b1);
      run_phase(13'd17, 70, 1'b0);
      run_phase(13'd2, 70, 1'b1);
      run_phase(IDX_W'($urandom_range(4, 64)), 70, 1'b1);
      run_phase(IDX_W'($urandom_range(1, 8191)), 70, 1'b0);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_count == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
